FILE: sv/lcd4_pkg.sv
// Shared types, constants and tables for the 4-bit character LCD controller.
// Used by every module of the block; depends on nothing else.
package lcd4_pkg;

    // Default values of the top-level parameters.
    localparam int TICK_COUNTER_BITS_DEF  = 20;
    localparam int INIT_COMMAND_COUNT_DEF = 6;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] CFG_POWERUP_WAIT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_PULSE     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_LONG_GAP  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUS_PULSE      = 2'd3;

    localparam int POWERUP_W = 20;
    localparam int INIT_W    = 16;
    localparam int BUS_W     = 8;
    localparam int LEN_W     = 20;

    localparam logic [POWERUP_W-1:0] POWERUP_WAIT_RST  = 20'd60000;
    localparam logic [INIT_W-1:0]    INIT_PULSE_RST    = 16'd1000;
    localparam logic [INIT_W-1:0]    INIT_LONG_GAP_RST = 16'd5000;
    localparam logic [BUS_W-1:0]     BUS_PULSE_RST     = 8'd1;

    // Request codes carried in the cmd field.
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_INSTR  = 2'd1;
    localparam logic [1:0] CMD_CHAR   = 2'd2;
    localparam logic [1:0] CMD_CURSOR = 2'd3;

    // Nibble levels on the data lines.
    localparam logic [3:0] NIB_WAKE     = 4'h3;
    localparam logic [3:0] NIB_FOURBIT  = 4'h2;
    localparam logic [3:0] NIB_RELEASED = 4'hF;

    // Short queue between the classifier and the sequencer.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        PH_POWERUP,
        PH_INIT,
        PH_WRITE,
        PH_POLL,
        PH_IDLE
    } phase_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] byte_value;
        logic [2:0] cursor_row;
        logic [4:0] cursor_column;
        logic       busy_in;
    } item_t;

    typedef struct packed {
        logic       reg_select;
        logic       read_write;
        logic       enable;
        logic [3:0] nibble;
        logic       drive_bus;
        logic       ready_res;
        logic       accepted;
    } result_t;

    // A classified beat as the sequencer sees it.
    typedef struct packed {
        logic       req;
        logic       is_data;
        logic [7:0] pend_byte;
        logic       busy;
    } cls_t;

    // Timing registers handed to the sequencer.
    typedef struct packed {
        logic [POWERUP_W-1:0] powerup_wait;
        logic [INIT_W-1:0]    init_pulse;
        logic [INIT_W-1:0]    init_long_gap;
        logic [BUS_W-1:0]     bus_pulse;
    } timing_t;

    // DDRAM base address of each display row.
    function automatic logic [7:0] cursor_base(input logic [1:0] row_idx);
        logic [7:0] base;
        case (row_idx)
            2'd0:    base = 8'h80;
            2'd1:    base = 8'hC0;
            2'd2:    base = 8'h90;
            default: base = 8'hD0;
        endcase
        return base;
    endfunction

    // Instructions written after the wake-up pulses; spare entries hold
    // display-on with blinking cursor.
    function automatic logic [7:0] init_seq(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'h28;
            3'd1:    val = 8'h01;
            3'd2:    val = 8'h08;
            3'd3:    val = 8'h0C;
            3'd4:    val = 8'h06;
            3'd5:    val = 8'h01;
            default: val = 8'h0F;
        endcase
        return val;
    endfunction

endpackage

FILE: sv/char_lcd_4bit_controller_unit.sv
// Top level of the 4-bit character LCD controller: timing registers and the
// front, queue and sequencer stages. Depends on lcd4_pkg, lcd4_front,
// lcd4_queue and lcd4_seq.

// Each input beat is one display tick and may carry a request: write an
// instruction byte, write a character byte, or move the cursor to a row of one
// to four and a one-based column. Every input beat yields exactly one result
// beat with the RS, RW, E and DB4 to DB7 levels for that tick, the bus drive
// flag, an idle flag and an accepted flag; a request is taken only when the
// idle flag of the same result beat is high, otherwise it is dropped with
// accepted low. After reset the controller holds nibble 3 for the power-up
// wait, gives the wake-up pulses and the switch to four-bit mode, writes the
// six start-up instructions, and polls the busy flag after every byte before
// going idle. All timing is counted in input beats, not clocks, through the
// four timing registers written on the configuration port (cfg_ready is always
// high; write them only while no results are outstanding). The block takes one
// beat per clock while the queue is not full: the front classifier feeds a
// two-entry queue, and the sequencer consumes one queued beat per clock into a
// registered result stage whenever the result side keeps up, so each accepted
// beat is held in the queue and then registered as its result beat.
module char_lcd_4bit_controller_unit
#(
    parameter int TICK_COUNTER_BITS  = lcd4_pkg::TICK_COUNTER_BITS_DEF,
    parameter int INIT_COMMAND_COUNT = lcd4_pkg::INIT_COMMAND_COUNT_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  lcd4_pkg::item_t                  item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output lcd4_pkg::result_t                result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lcd4_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lcd4_pkg::CFG_DATA_W-1:0]  cfg_data
);

    lcd4_pkg::timing_t timing_reg;
    lcd4_pkg::cls_t    cls;
    lcd4_pkg::cls_t    head;
    logic              head_valid;
    logic              q_full;
    logic              pop;

    // Register writes never stall.
    assign cfg_ready  = 1'b1;
    assign item_ready = !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.powerup_wait  <= lcd4_pkg::POWERUP_WAIT_RST;
            timing_reg.init_pulse    <= lcd4_pkg::INIT_PULSE_RST;
            timing_reg.init_long_gap <= lcd4_pkg::INIT_LONG_GAP_RST;
            timing_reg.bus_pulse     <= lcd4_pkg::BUS_PULSE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lcd4_pkg::CFG_POWERUP_WAIT:
                    timing_reg.powerup_wait <= cfg_data[lcd4_pkg::POWERUP_W-1:0];
                lcd4_pkg::CFG_INIT_PULSE:
                    timing_reg.init_pulse <= cfg_data[lcd4_pkg::INIT_W-1:0];
                lcd4_pkg::CFG_INIT_LONG_GAP:
                    timing_reg.init_long_gap <= cfg_data[lcd4_pkg::INIT_W-1:0];
                default:
                    timing_reg.bus_pulse <= cfg_data[lcd4_pkg::BUS_W-1:0];
            endcase
        end
    end

    lcd4_front u_front
    (
        .item (item),
        .cls  (cls)
    );

    lcd4_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (item_valid && item_ready),
        .push_data (cls),
        .pop       (pop),
        .head      (head),
        .not_empty (head_valid),
        .full      (q_full)
    );

    lcd4_seq
    #(
        .TICK_COUNTER_BITS  (TICK_COUNTER_BITS),
        .INIT_COMMAND_COUNT (INIT_COMMAND_COUNT)
    )
    u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .timing       (timing_reg),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

FILE: sv/lcd4_front.sv
// Front classifier: decodes one input beat into a request flag and the byte
// to be written. Depends on lcd4_pkg.
module lcd4_front
(
    input  lcd4_pkg::item_t item,
    output lcd4_pkg::cls_t  cls
);

    logic [1:0] row_idx;
    logic [7:0] cursor_addr;
    logic       row_ok;

    assign row_idx     = 2'(item.cursor_row - 3'd1);
    assign row_ok      = (item.cursor_row >= 3'd1) && (item.cursor_row <= 3'd4);
    // Column is one based; the address wraps within the byte.
    assign cursor_addr = lcd4_pkg::cursor_base(row_idx) + {3'b000, item.cursor_column} - 8'd1;

    always_comb
    begin
        cls.busy      = item.busy_in;
        cls.req       = 1'b0;
        cls.is_data   = 1'b0;
        cls.pend_byte = item.byte_value;
        unique case (item.cmd)
            lcd4_pkg::CMD_INSTR:
            begin
                cls.req = 1'b1;
            end
            lcd4_pkg::CMD_CHAR:
            begin
                cls.req     = 1'b1;
                cls.is_data = 1'b1;
            end
            lcd4_pkg::CMD_CURSOR:
            begin
                cls.req       = row_ok;
                cls.pend_byte = cursor_addr;
            end
            default:
            begin
                cls.req = 1'b0;
            end
        endcase
    end

endmodule

FILE: sv/lcd4_queue.sv
// Short FIFO of classified beats between the front classifier and the
// sequencer. Depends on lcd4_pkg for the entry type and depth.
module lcd4_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lcd4_pkg::cls_t push_data,
    input  logic           pop,
    output lcd4_pkg::cls_t head,
    output logic           not_empty,
    output logic           full
);

    localparam int DEPTH = lcd4_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcd4_pkg::cls_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/lcd4_seq.sv
// Back sequencer: steps the display timing state machine once per classified
// beat and registers the pin levels for the output. Depends on lcd4_pkg.
module lcd4_seq
#(
    parameter int TICK_COUNTER_BITS  = lcd4_pkg::TICK_COUNTER_BITS_DEF,
    parameter int INIT_COMMAND_COUNT = lcd4_pkg::INIT_COMMAND_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  lcd4_pkg::timing_t timing,
    input  lcd4_pkg::cls_t    head,
    input  logic              head_valid,
    output logic              pop,
    output lcd4_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_ready
);

    localparam int TCB   = TICK_COUNTER_BITS;
    localparam int CMP_W = ((TCB > lcd4_pkg::LEN_W) ? TCB : lcd4_pkg::LEN_W) + 1;

    lcd4_pkg::phase_t   phase_reg;
    lcd4_pkg::phase_t   phase_next;
    logic [2:0]         sub_reg;
    logic [2:0]         sub_next;
    logic [TCB-1:0]     tick_reg;
    logic [TCB-1:0]     tick_next;
    logic [7:0]         pend_byte_reg;
    logic [7:0]         pend_byte_next;
    logic               is_data_reg;
    logic               is_data_next;
    logic [2:0]         init_idx_reg;
    logic [2:0]         init_idx_next;
    logic               init_run_reg;
    logic               init_run_next;
    logic               busy_seen_reg;
    logic               busy_seen_next;
    lcd4_pkg::result_t  result_reg;
    lcd4_pkg::result_t  result_next;
    logic               result_valid_reg;

    logic [lcd4_pkg::LEN_W-1:0] len_raw;
    logic [lcd4_pkg::LEN_W-1:0] len;
    logic [CMP_W-1:0]           tick_inc;
    logic                       step_end;
    logic                       step;
    logic                       more_init;

    // One beat is consumed whenever the output slot is free or being emptied.
    assign step         = head_valid && (!result_valid_reg || result_ready);
    assign pop          = step;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    always_comb
    begin
        case (phase_reg)
            lcd4_pkg::PH_POWERUP: len_raw = timing.powerup_wait;
            lcd4_pkg::PH_INIT:    len_raw = (sub_reg == 3'd1)
                                            ? lcd4_pkg::LEN_W'(timing.init_long_gap)
                                            : lcd4_pkg::LEN_W'(timing.init_pulse);
            default:              len_raw = lcd4_pkg::LEN_W'(timing.bus_pulse);
        endcase
    end

    // A length of zero behaves as one tick.
    assign len       = (len_raw == '0) ? lcd4_pkg::LEN_W'(1) : len_raw;
    assign tick_inc  = CMP_W'(tick_reg) + CMP_W'(1);
    assign step_end  = (tick_inc >= CMP_W'(len)) || (&tick_reg);
    assign more_init = ({1'b0, init_idx_reg} + 4'd1) < 4'(INIT_COMMAND_COUNT);

    always_comb
    begin
        phase_next     = phase_reg;
        sub_next       = sub_reg;
        tick_next      = tick_reg;
        pend_byte_next = pend_byte_reg;
        is_data_next   = is_data_reg;
        init_idx_next  = init_idx_reg;
        init_run_next  = init_run_reg;
        busy_seen_next = busy_seen_reg;

        result_next.reg_select = 1'b0;
        result_next.read_write = 1'b0;
        result_next.enable     = 1'b0;
        result_next.nibble     = lcd4_pkg::NIB_RELEASED;
        result_next.drive_bus  = 1'b0;
        result_next.ready_res  = 1'b0;
        result_next.accepted   = 1'b0;

        // Pin levels reflect the state at the start of the beat.
        unique case (phase_reg)
            lcd4_pkg::PH_POWERUP:
            begin
                result_next.nibble    = lcd4_pkg::NIB_WAKE;
                result_next.drive_bus = 1'b1;
            end
            lcd4_pkg::PH_INIT:
            begin
                result_next.enable    = ~sub_reg[0];
                result_next.nibble    = (sub_reg < 3'd6) ? lcd4_pkg::NIB_WAKE
                                                         : lcd4_pkg::NIB_FOURBIT;
                result_next.drive_bus = 1'b1;
            end
            lcd4_pkg::PH_WRITE:
            begin
                result_next.reg_select = is_data_reg;
                result_next.enable     = ~sub_reg[0];
                result_next.nibble     = (sub_reg < 3'd2) ? pend_byte_reg[7:4]
                                                          : pend_byte_reg[3:0];
                result_next.drive_bus  = 1'b1;
            end
            lcd4_pkg::PH_POLL:
            begin
                result_next.read_write = 1'b1;
                result_next.enable     = ~sub_reg[0];
            end
            default:
            begin
                result_next.read_write = 1'b1;
                result_next.ready_res  = 1'b1;
            end
        endcase

        if (phase_reg == lcd4_pkg::PH_IDLE)
        begin
            if (head.req)
            begin
                result_next.accepted = 1'b1;
                pend_byte_next       = head.pend_byte;
                is_data_next         = head.is_data;
                phase_next           = lcd4_pkg::PH_WRITE;
                sub_next             = '0;
                tick_next            = '0;
            end
        end
        else
        begin
            if ((phase_reg == lcd4_pkg::PH_POLL) && (sub_reg == 3'd0) && (tick_reg == '0))
            begin
                busy_seen_next = head.busy;
            end
            if (step_end)
            begin
                tick_next = '0;
                sub_next  = sub_reg + 3'd1;
                unique case (phase_reg)
                    lcd4_pkg::PH_POWERUP:
                    begin
                        phase_next = lcd4_pkg::PH_INIT;
                        sub_next   = '0;
                    end
                    lcd4_pkg::PH_INIT:
                    begin
                        if (sub_reg == 3'd7)
                        begin
                            init_run_next  = 1'b1;
                            init_idx_next  = '0;
                            pend_byte_next = lcd4_pkg::init_seq(3'd0);
                            is_data_next   = 1'b0;
                            phase_next     = lcd4_pkg::PH_WRITE;
                            sub_next       = '0;
                        end
                    end
                    lcd4_pkg::PH_WRITE:
                    begin
                        if (sub_reg == 3'd3)
                        begin
                            phase_next = lcd4_pkg::PH_POLL;
                            sub_next   = '0;
                        end
                    end
                    lcd4_pkg::PH_POLL:
                    begin
                        if (sub_reg == 3'd3)
                        begin
                            sub_next = '0;
                            if (!busy_seen_reg)
                            begin
                                if (init_run_reg && more_init)
                                begin
                                    init_idx_next  = init_idx_reg + 3'd1;
                                    pend_byte_next = lcd4_pkg::init_seq(init_idx_reg + 3'd1);
                                    is_data_next   = 1'b0;
                                    phase_next     = lcd4_pkg::PH_WRITE;
                                end
                                else
                                begin
                                    init_run_next = 1'b0;
                                    phase_next    = lcd4_pkg::PH_IDLE;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            else
            begin
                tick_next = tick_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lcd4_pkg::PH_POWERUP;
            sub_reg       <= '0;
            tick_reg      <= '0;
            pend_byte_reg <= '0;
            is_data_reg   <= 1'b0;
            init_idx_reg  <= '0;
            init_run_reg  <= 1'b0;
            busy_seen_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            sub_reg       <= sub_next;
            tick_reg      <= tick_next;
            pend_byte_reg <= pend_byte_next;
            is_data_reg   <= is_data_next;
            init_idx_reg  <= init_idx_next;
            init_run_reg  <= init_run_next;
            busy_seen_reg <= busy_seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

endmodule
